// ===== hdl/apd_pkg.sv =====
// Shared constants for the adaptive playout delay block.
package apd_pkg;

  localparam int unsigned WindowDef  = 32;
  localparam int unsigned WarmupDef  = 16;

  localparam int unsigned TimeW      = 40;
  localparam int unsigned OffsetW    = 41;
  localparam int unsigned DelayW     = 21;
  localparam int unsigned ResidW     = 32;
  localparam int unsigned CfgIdxW    = 2;

  localparam logic [CfgIdxW-1:0] CfgDelayMin   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDelayMax   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDelayStart = 2'd2;

  localparam logic [DelayW-1:0] DelayMinRst   = 21'd50000;
  localparam logic [DelayW-1:0] DelayMaxRst   = 21'd300000;
  localparam logic [DelayW-1:0] DelayStartRst = 21'd100000;

  localparam logic [14:0] OffsetGain = 15'd6554;
  localparam logic [14:0] DelayGain  = 15'd9830;
  // Q16 reciprocal of ten, exact for the small percentile positions
  localparam logic [12:0] RecipTen   = 13'd6554;

  // interpolation span: neighbors in the sorted window differ by less than 2^32
  localparam int unsigned InterpW    = 32;

endpackage

// ===== hdl/apd_ram.sv =====
// Generic single-port-write, registered-read RAM.
module apd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/apd_div10.sv =====
// Registered floor(span * digit / 10) by reciprocal multiplication.
module apd_div10 (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [apd_pkg::InterpW-1:0] dividend_i,
  input  logic [3:0]                  digit_i,
  output logic                        done_o,
  output logic [apd_pkg::InterpW-1:0] quot_o
);
  import apd_pkg::*;

  // ceil(2^35 / 10): exact quotient for any 32-bit dividend
  localparam logic [31:0] Recip10   = 32'hCCCC_CCCD;
  // ceil(2^11 / 10): exact for products below 100
  localparam logic [15:0] RecipSmall = 16'd205;
  localparam logic [3:0]  Ten        = 4'd10;

  logic               stage_q, done_q;
  logic [InterpW-1:0] num_q;
  logic [3:0]         dig_q;
  logic [28:0]        tq_q, tq_d;
  logic [InterpW-1:0] quot_q, quot_d;
  logic [63:0]        prod;
  logic [InterpW-1:0] tq_ten;
  logic [3:0]         rem;
  logic [7:0]         rem_dig;
  logic [15:0]        part_prod;
  logic [3:0]         part;

  // span = 10*q + r, so span*digit/10 = q*digit + floor(r*digit/10)
  always_comb begin
    prod      = 64'(dividend_i) * 64'(Recip10);
    tq_d      = prod[63:35];
    tq_ten    = InterpW'(tq_q) * InterpW'(Ten);
    rem       = 4'(num_q - tq_ten);
    rem_dig   = 8'(rem) * 8'(dig_q);
    part_prod = 16'(rem_dig) * RecipSmall;
    part      = part_prod[14:11];
    quot_d    = InterpW'(tq_q) * InterpW'(dig_q) + InterpW'(part);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      stage_q <= start_i;
      done_q  <= stage_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      dig_q <= digit_i;
      tq_q  <= tq_d;
    end
    if (stage_q) begin
      quot_q <= quot_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== hdl/adaptive_playout_delay.sv =====
// Time from request accept to result grows with n, the samples held after it: the
// merge into the sorted-window RAM sets it, plus two percentile reads (median and
// 90th) that are skipped while the window is not warm.
// One request is in work at a time; the next is taken once the result is posted,
// and a posted result waits in the output register meanwhile. No clearing pass.
// Reset: asynchronous, active low; window empty, delay at the start value.
module adaptive_playout_delay #(
  parameter int unsigned WINDOW = apd_pkg::WindowDef,
  parameter int unsigned WARMUP = apd_pkg::WarmupDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [apd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [apd_pkg::DelayW-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [apd_pkg::TimeW-1:0]    arrival_time_us_i,
  input  logic [apd_pkg::TimeW-1:0]    sender_time_us_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [apd_pkg::DelayW-1:0]   delay_us_o,
  output logic                         warm_o,
  output logic signed [apd_pkg::OffsetW-1:0] offset_est_us_o
);
  import apd_pkg::*;

  localparam int unsigned IW = $clog2(WINDOW);
  localparam int unsigned CW = $clog2(WINDOW + 1);
  localparam int unsigned PW = CW + 4;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_OFS  = 4'd1;
  localparam logic [3:0] S_EST  = 4'd2;
  localparam logic [3:0] S_RES  = 4'd3;
  localparam logic [3:0] S_MRD  = 4'd4;
  localparam logic [3:0] S_MDEC = 4'd5;
  localparam logic [3:0] S_PA   = 4'd6;
  localparam logic [3:0] S_PB   = 4'd7;
  localparam logic [3:0] S_PC   = 4'd8;
  localparam logic [3:0] S_PW   = 4'd9;
  localparam logic [3:0] S_TGT  = 4'd10;
  localparam logic [3:0] S_DLY  = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  logic [3:0] state_q, state_d;

  logic [DelayW-1:0] dmin_q, dmax_q;

  logic                      sync_q, sync_d;
  logic signed [OffsetW-1:0] raw_q, raw_d;
  logic signed [OffsetW-1:0] est_q, est_d;
  logic signed [55:0]        oprod_q, oprod_d;
  logic signed [ResidW-1:0]  resid_q, resid_d;
  logic signed [ResidW-1:0]  old_q, old_d;
  logic [IW-1:0]             head_q, head_d;
  logic [CW-1:0]             count_q, count_d;
  logic [CW-1:0]             nold_q, nold_d;
  logic                      full_q, full_d;
  logic                      bank_q, bank_d;
  logic [CW-1:0]             r_q, r_d, w_q, w_d;
  logic                      ins_q, ins_d, rmv_q, rmv_d;
  logic                      ksel_q, ksel_d;
  logic signed [ResidW-1:0]  a_q, a_d;
  logic signed [33:0]        med_q, med_d, p90_q, p90_d;
  logic signed [37:0]        dprod_q, dprod_d;
  logic [DelayW-1:0]         smooth_q, smooth_d;
  logic                      warm_q, warm_d;

  logic                      ovalid_q, ovalid_d;
  logic [DelayW-1:0]         odelay_q, odelay_d;
  logic                      owarm_q, owarm_d;
  logic signed [OffsetW-1:0] oest_q, oest_d;

  // ring memory of residuals in arrival order
  logic              ring_we;
  logic [IW-1:0]     ring_raddr;
  logic [ResidW-1:0] ring_rdata;

  // sorted copy, two banks: read one, merge into the other
  logic              srt_we;
  logic [IW:0]       srt_waddr, srt_raddr;
  logic [ResidW-1:0] srt_wdata, srt_rdata;

  logic              div_start, div_done;
  logic [InterpW-1:0] div_in, div_q;

  apd_ram #(.Width(ResidW), .Depth(WINDOW)) u_ring (
    .clk_i, .we_i(ring_we), .waddr_i(head_q), .wdata_i(resid_q),
    .raddr_i(ring_raddr), .rdata_o(ring_rdata)
  );

  apd_ram #(.Width(ResidW), .Depth(2 ** (IW + 1))) u_sorted (
    .clk_i, .we_i(srt_we), .waddr_i(srt_waddr), .wdata_i(srt_wdata),
    .raddr_i(srt_raddr), .rdata_o(srt_rdata)
  );

  // percentile position k*(n-1): index and tenths
  logic [PW-1:0]    pos;
  logic [PW+12:0]   recip;
  logic [IW-1:0]    i0, i1;
  logic [PW-1:0]    i0_ten;
  logic [3:0]       frac;
  logic [CW-1:0]    i0_inc;

  always_comb begin
    pos    = PW'(ksel_q ? 4'd9 : 4'd5) * PW'(count_q - 1'b1);
    recip  = (PW+13)'(pos) * (PW+13)'(RecipTen);
    i0     = recip[16 +: IW];
    i0_ten = PW'(i0) * PW'(4'd10);
    frac   = 4'(pos - i0_ten);
    i0_inc = CW'(i0) + 1'b1;
    i1     = (i0_inc < count_q) ? i0_inc[IW-1:0] : IW'(count_q - 1'b1);
  end

  apd_div10 u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_in), .digit_i(frac),
    .done_o(div_done), .quot_o(div_q)
  );

  logic signed [ResidW-1:0] s_val;
  logic                     s_ok;
  logic signed [41:0]       odiff, rdiff;
  logic signed [32:0]       idiff;
  logic signed [34:0]       tsum;
  logic signed [33:0]       tgt;
  logic signed [22:0]       ddiff;
  logic signed [33:0]       pval;

  always_comb begin
    state_d  = state_q;
    sync_d   = sync_q;
    raw_d    = raw_q;
    est_d    = est_q;
    oprod_d  = oprod_q;
    resid_d  = resid_q;
    old_d    = old_q;
    head_d   = head_q;
    count_d  = count_q;
    nold_d   = nold_q;
    full_d   = full_q;
    bank_d   = bank_q;
    r_d      = r_q;
    w_d      = w_q;
    ins_d    = ins_q;
    rmv_d    = rmv_q;
    ksel_d   = ksel_q;
    a_d      = a_q;
    med_d    = med_q;
    p90_d    = p90_q;
    dprod_d  = dprod_q;
    smooth_d = smooth_q;
    warm_d   = warm_q;
    ovalid_d = ovalid_q && out_stall_i;
    odelay_d = odelay_q;
    owarm_d  = owarm_q;
    oest_d   = oest_q;

    ring_we    = 1'b0;
    ring_raddr = head_q;
    srt_we     = 1'b0;
    srt_waddr  = {~bank_q, w_q[IW-1:0]};
    srt_wdata  = resid_q;
    srt_raddr  = {bank_q, r_q[IW-1:0]};
    div_start  = 1'b0;

    s_val = $signed(srt_rdata);
    s_ok  = (r_q < nold_q);
    odiff = 42'(raw_q) - 42'(est_q);
    rdiff = 42'(raw_q) - 42'(est_q);
    idiff = 33'(s_val) - 33'(a_q);
    // sorted order keeps the span non-negative
    div_in = idiff[InterpW-1:0];
    pval  = 34'(a_q) + $signed({2'b0, div_q});
    tsum  = 35'(med_q) + 35'(p90_q);
    tgt   = 34'(tsum >>> 1);
    ddiff = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          raw_d   = $signed({1'b0, arrival_time_us_i}) - $signed({1'b0, sender_time_us_i});
          state_d = S_OFS;
        end
      end
      S_OFS: begin
        oprod_d = 56'(odiff) * 56'($signed({1'b0, OffsetGain}));
        state_d = S_EST;
      end
      S_EST: begin
        old_d   = $signed(ring_rdata);
        est_d   = sync_q ? est_q + OffsetW'(oprod_q >>> 16) : raw_q;
        sync_d  = 1'b1;
        state_d = S_RES;
      end
      S_RES: begin
        if (rdiff > 42'sd2147483647) begin
          resid_d = 32'sh7FFFFFFF;
        end else if (rdiff < -42'sd2147483648) begin
          resid_d = 32'sh80000000;
        end else begin
          resid_d = ResidW'(rdiff);
        end
        state_d = S_MRD;
      end
      S_MRD: begin
        // resid_q now settled: store it and open the merge
        if (r_q == '0 && w_q == '0 && !ins_q && !rmv_q && !full_q && nold_q == count_q) begin
          ring_we = 1'b1;
          head_d  = (CW'(head_q) + 1'b1 == CW'(WINDOW)) ? '0 : head_q + 1'b1;
          full_d  = (count_q == CW'(WINDOW));
          if (count_q != CW'(WINDOW)) begin
            count_d = count_q + 1'b1;
          end
        end
        state_d = S_MDEC;
      end
      S_MDEC: begin
        if (full_q && !rmv_q && s_ok && s_val == old_q) begin
          rmv_d   = 1'b1;
          r_d     = r_q + 1'b1;
          state_d = S_MRD;
        end else begin
          srt_we = 1'b1;
          w_d    = w_q + 1'b1;
          if (!ins_q && (!s_ok || resid_q <= s_val)) begin
            ins_d = 1'b1;
          end else begin
            srt_wdata = srt_rdata;
            r_d       = r_q + 1'b1;
          end
          if (w_q + 1'b1 == count_q) begin
            bank_d  = ~bank_q;
            r_d     = '0;
            w_d     = '0;
            ins_d   = 1'b0;
            rmv_d   = 1'b0;
            full_d  = 1'b0;
            nold_d  = count_q;
            ksel_d  = 1'b0;
            warm_d  = (32'(count_q) >= 32'(WARMUP));
            state_d = (32'(count_q) >= 32'(WARMUP)) ? S_PA : S_DONE;
          end else begin
            state_d = S_MRD;
          end
        end
      end
      S_PA: begin
        srt_raddr = {bank_q, i0};
        state_d   = S_PB;
      end
      S_PB: begin
        a_d       = s_val;
        srt_raddr = {bank_q, i1};
        state_d   = S_PC;
      end
      S_PC: begin
        div_start = 1'b1;
        state_d   = S_PW;
      end
      S_PW: begin
        if (div_done) begin
          if (ksel_q) begin
            p90_d   = pval;
            state_d = S_TGT;
          end else begin
            med_d   = pval;
            ksel_d  = 1'b1;
            state_d = S_PA;
          end
        end
      end
      S_TGT: begin
        if (tgt < $signed({13'd0, dmin_q})) begin
          ddiff = $signed({2'b0, dmin_q}) - $signed({2'b0, smooth_q});
        end else if (tgt >= $signed({13'd0, dmax_q})) begin
          ddiff = $signed({2'b0, dmax_q}) - $signed({2'b0, smooth_q});
        end else begin
          ddiff = 23'(tgt) - $signed({2'b0, smooth_q});
        end
        dprod_d = 38'(ddiff) * 38'($signed({1'b0, DelayGain}));
        state_d = S_DLY;
      end
      S_DLY: begin
        smooth_d = DelayW'($signed({1'b0, smooth_q}) + 22'(dprod_q >>> 16));
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (!ovalid_q || !out_stall_i) begin
          ovalid_d = 1'b1;
          odelay_d = smooth_q;
          owarm_d  = warm_q;
          oest_d   = est_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_we_i) begin
      // applied in the register block below
    end
  end

  // S_MRD stores the residual only on the first pass of an item
  // (merge counters and the full flag are all clear, and nold matches count, only then)

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      dmin_q   <= DelayMinRst;
      dmax_q   <= DelayMaxRst;
      sync_q   <= 1'b0;
      est_q    <= '0;
      head_q   <= '0;
      count_q  <= '0;
      nold_q   <= '0;
      full_q   <= 1'b0;
      bank_q   <= 1'b0;
      r_q      <= '0;
      w_q      <= '0;
      ins_q    <= 1'b0;
      rmv_q    <= 1'b0;
      ksel_q   <= 1'b0;
      smooth_q <= DelayStartRst;
      warm_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      sync_q   <= sync_d;
      est_q    <= est_d;
      head_q   <= head_d;
      count_q  <= count_d;
      nold_q   <= nold_d;
      full_q   <= full_d;
      bank_q   <= bank_d;
      r_q      <= r_d;
      w_q      <= w_d;
      ins_q    <= ins_d;
      rmv_q    <= rmv_d;
      ksel_q   <= ksel_d;
      smooth_q <= smooth_d;
      warm_q   <= warm_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgDelayMin: dmin_q <= cfg_wdata_i;
          CfgDelayMax: dmax_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q    <= raw_d;
    oprod_q  <= oprod_d;
    resid_q  <= resid_d;
    old_q    <= old_d;
    a_q      <= a_d;
    med_q    <= med_d;
    p90_q    <= p90_d;
    dprod_q  <= dprod_d;
    odelay_q <= odelay_d;
    owarm_q  <= owarm_d;
    oest_q   <= oest_d;
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = ovalid_q;
  assign delay_us_o      = odelay_q;
  assign warm_o          = owarm_q;
  assign offset_est_us_o = oest_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(WINDOW))
    else $error("window count beyond depth");

  a_merge_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    srt_we |-> (w_q < count_q))
    else $error("merge writes past the new sample count");

  a_merge_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MDEC) |-> (r_q <= nold_q))
    else $error("merge read pointer overran old list");

  a_warm_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PA) |-> (32'(count_q) >= 32'(WARMUP)))
    else $error("percentile pass without warm window");

endmodule
